// File: rtl/cmbp_pkg.sv
package cmbp_pkg;

  // Default sizes of the model.
  localparam int UNITS_DEF      = 4;
  localparam int TREE_NODES_DEF = 256;
  localparam int SYMBOLS_DEF    = 256;
  localparam int PROB_BITS_DEF  = 12;

  // Fixed field widths of the request and result channels.
  localparam int OP_W       = 2;
  localparam int TREE_W     = 8;
  localparam int BYTE_W     = 8;
  localparam int PROB_OUT_W = 12;

  // An entry moves by this fraction (as a right shift) toward its target.
  localparam int MOVE_SHIFT = 1;

  typedef enum logic [OP_W-1:0] {
    OP_PREDICT = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_PUSH    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_MIX,
    ST_SCALE,
    ST_FIX
  } state_t;

  // Sum of the unit weights (units - u)^2 over all units.
  function automatic int weight_sum(input int units);
    int acc;
    acc = 0;
    for (int u = 0; u < units; u++) begin
      acc = acc + (units - u) * (units - u);
    end
    return acc;
  endfunction

endpackage

// File: rtl/cmbp_if.sv
interface cmbp_in_if;
  logic                          valid;
  logic                          ready;
  logic [cmbp_pkg::OP_W-1:0]     operation;
  logic [cmbp_pkg::TREE_W-1:0]   tree_node;
  logic                          bit_req;
  logic [cmbp_pkg::BYTE_W-1:0]   byte_value;

  modport source(output valid, output operation, output tree_node, output bit_req,
                 output byte_value, input ready);
  modport sink(input valid, input operation, input tree_node, input bit_req,
               input byte_value, output ready);
endinterface

interface cmbp_out_if;
  logic                            valid;
  logic                            ready;
  logic [cmbp_pkg::PROB_OUT_W-1:0] probability;

  modport source(output valid, output probability, input ready);
  modport sink(input valid, input probability, output ready);
endinterface

// File: rtl/context_mixed_bit_probability_model_unit.sv
// Bit-probability model for a binary arithmetic coder. Each history unit u owns one probability
// bank, addressed by the byte seen u+1 positions back and by the bit-tree node; all banks are
// read in parallel through their single read port. A push request is done once it is accepted; an update
// request does a bank read, then a write-back of the moved entries, and the next request waits for
// the write; a predict request does a bank read, weighted sum, reciprocal multiply and quotient
// correction, which waits until the result register is free or is taken by the consumer. After reset
// the banks are filled with half scale, one row per cycle, over all
// 2^(clog2(SYMBOLS)+clog2(TREE_NODES)) rows (65536 with the default sizes); no request is
// accepted until that pass ends.
module context_mixed_bit_probability_model_unit #(
  parameter int UNITS      = cmbp_pkg::UNITS_DEF,
  parameter int TREE_NODES = cmbp_pkg::TREE_NODES_DEF,
  parameter int SYMBOLS    = cmbp_pkg::SYMBOLS_DEF,
  parameter int PROB_BITS  = cmbp_pkg::PROB_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  cmbp_in_if.sink     in_chan,
  cmbp_out_if.source  out_chan
);

  localparam int SYM_BITS  = $clog2(SYMBOLS);
  localparam int NODE_BITS = $clog2(TREE_NODES);
  localparam int ADDR_W    = SYM_BITS + NODE_BITS;
  localparam int WSUM      = cmbp_pkg::weight_sum(UNITS);
  localparam int ACC_W     = PROB_BITS + $clog2(WSUM + 1);
  localparam int PROD_W    = 2 * ACC_W;
  localparam int TAB_N     = 2 ** cmbp_pkg::BYTE_W;
  localparam int NODE_N    = 2 ** cmbp_pkg::TREE_W;

  localparam logic [ACC_W-1:0]     WSUM_V = ACC_W'(WSUM);
  // Floor reciprocal of the weight sum; the quotient estimate is low by at most one.
  localparam logic [ACC_W-1:0]     RECIP  = ACC_W'((64'd1 << ACC_W) / WSUM);
  localparam logic [PROB_BITS-1:0] HALF   = PROB_BITS'(1) << (PROB_BITS - 1);
  localparam logic [PROB_BITS:0]   FULL   = (PROB_BITS + 1)'(1) << PROB_BITS;

  // Reduction tables for history bytes and tree nodes.
  logic [SYM_BITS-1:0]  sym_tab  [TAB_N];
  logic [NODE_BITS-1:0] node_tab [NODE_N];

  for (genvar i = 0; i < TAB_N; i++) begin : g_sym_tab
    assign sym_tab[i] = SYM_BITS'(i % SYMBOLS);
  end
  for (genvar i = 0; i < NODE_N; i++) begin : g_node_tab
    assign node_tab[i] = NODE_BITS'(i % TREE_NODES);
  end

  cmbp_pkg::state_t state_r, state_nxt;
  logic [ADDR_W-1:0]             clr_cnt_r, clr_cnt_nxt;
  logic [cmbp_pkg::BYTE_W-1:0]   hist_r [UNITS];
  logic [cmbp_pkg::BYTE_W-1:0]   hist_nxt [UNITS];
  logic [ADDR_W-1:0]             addr_r [UNITS];
  logic [ADDR_W-1:0]             addr_nxt [UNITS];
  logic                          bit_r, bit_nxt;
  logic [ACC_W-1:0]              acc_r, acc_nxt;
  logic [PROD_W-1:0]             prod_r, prod_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [PROB_BITS-1:0]          prob_r, prob_nxt;

  logic                 in_acc;
  cmbp_pkg::op_t        in_op;
  logic [NODE_BITS-1:0] node_idx;
  logic [ADDR_W-1:0]    rd_addr [UNITS];
  logic [PROB_BITS-1:0] rd_data [UNITS];
  logic [PROB_BITS-1:0] moved [UNITS];
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr [UNITS];
  logic [PROB_BITS-1:0] wr_data [UNITS];
  logic [ACC_W-1:0]     acc_sum;
  logic [PROB_BITS-1:0] q_est;
  logic [ACC_W-1:0]     rem;
  logic [PROB_BITS-1:0] q_fix;

  assign in_chan.ready = (state_r == cmbp_pkg::ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_op         = cmbp_pkg::op_t'(in_chan.operation);
  assign node_idx      = node_tab[in_chan.tree_node];

  assign out_chan.valid       = out_valid_r;
  assign out_chan.probability = cmbp_pkg::PROB_OUT_W'(prob_r);

  for (genvar u = 0; u < UNITS; u++) begin : g_unit
    assign rd_addr[u] = {sym_tab[hist_r[u]], node_idx};
    assign wr_addr[u] = (state_r == cmbp_pkg::ST_CLEAR) ? clr_cnt_r : addr_r[u];
    assign wr_data[u] = (state_r == cmbp_pkg::ST_CLEAR) ? HALF : moved[u];

    // A one bit pulls the entry halfway to zero, a zero bit halfway to full scale.
    always_comb begin
      if (bit_r) begin
        moved[u] = rd_data[u] - (rd_data[u] >> cmbp_pkg::MOVE_SHIFT);
      end else begin
        moved[u] = PROB_BITS'({1'b0, rd_data[u]}
                   + ((FULL - {1'b0, rd_data[u]}) >> cmbp_pkg::MOVE_SHIFT));
      end
    end

    cmbp_bank #(
      .ADDR_W(ADDR_W),
      .DATA_W(PROB_BITS)
    ) u_bank (
      .clk    (clk),
      .wr_en  (wr_en),
      .wr_addr(wr_addr[u]),
      .wr_data(wr_data[u]),
      .rd_en  (in_acc),
      .rd_addr(rd_addr[u]),
      .rd_data(rd_data[u])
    );
  end

  assign wr_en = (state_r == cmbp_pkg::ST_CLEAR) || (state_r == cmbp_pkg::ST_UPDATE);

  // Unit u is weighted by (UNITS - u)^2.
  always_comb begin
    acc_sum = '0;
    for (int u = 0; u < UNITS; u++) begin
      acc_sum = acc_sum + ACC_W'(rd_data[u]) * ACC_W'((UNITS - u) * (UNITS - u));
    end
  end

  assign q_est = PROB_BITS'(prod_r >> ACC_W);
  assign rem   = acc_r - ACC_W'(q_est) * WSUM_V;
  assign q_fix = (rem >= WSUM_V) ? PROB_BITS'(q_est + 1'b1) : q_est;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    hist_nxt      = hist_r;
    addr_nxt      = addr_r;
    bit_nxt       = bit_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    prob_nxt      = prob_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    case (state_r)
      cmbp_pkg::ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = cmbp_pkg::ST_IDLE;
        end
      end
      cmbp_pkg::ST_IDLE: begin
        if (in_acc) begin
          addr_nxt = rd_addr;
          bit_nxt  = in_chan.bit_req;
          case (in_op)
            cmbp_pkg::OP_PREDICT: state_nxt = cmbp_pkg::ST_MIX;
            cmbp_pkg::OP_UPDATE:  state_nxt = cmbp_pkg::ST_UPDATE;
            cmbp_pkg::OP_PUSH: begin
              for (int u = UNITS - 1; u > 0; u--) begin
                hist_nxt[u] = hist_r[u - 1];
              end
              hist_nxt[0] = in_chan.byte_value;
            end
            default: ;
          endcase
        end
      end
      cmbp_pkg::ST_UPDATE: begin
        state_nxt = cmbp_pkg::ST_IDLE;
      end
      cmbp_pkg::ST_MIX: begin
        acc_nxt   = acc_sum;
        state_nxt = cmbp_pkg::ST_SCALE;
      end
      cmbp_pkg::ST_SCALE: begin
        prod_nxt  = PROD_W'(acc_r) * PROD_W'(RECIP);
        state_nxt = cmbp_pkg::ST_FIX;
      end
      cmbp_pkg::ST_FIX: begin
        // The result register must be free or emptying this cycle.
        if (!out_valid_r || out_chan.ready) begin
          prob_nxt      = q_fix;
          out_valid_nxt = 1'b1;
          state_nxt     = cmbp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cmbp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cmbp_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int u = 0; u < UNITS; u++) begin
        hist_r[u] <= '0;
      end
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      hist_r      <= hist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    bit_r  <= bit_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    prob_r <= prob_nxt;
  end

endmodule

// File: rtl/cmbp_bank.sv
module cmbp_bank #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = cmbp_pkg::PROB_BITS_DEF
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: tb/context_mixed_bit_probability_model_unit_tb.sv
module context_mixed_bit_probability_model_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UNITS      = cmbp_pkg::UNITS_DEF;
  localparam int TREE_NODES = cmbp_pkg::TREE_NODES_DEF;
  localparam int SYMBOLS    = cmbp_pkg::SYMBOLS_DEF;
  localparam int PROB_BITS  = cmbp_pkg::PROB_BITS_DEF;

  localparam int unsigned FULL_SCALE = 1 << PROB_BITS;
  localparam int unsigned HALF_SCALE = 1 << (PROB_BITS - 1);

  localparam logic [cmbp_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int ITEM_TARGET    = 850;
  localparam int TAIL_ITEMS     = 120;
  localparam int LONG_HOLD      = 64;
  localparam int HOLD_AFTER     = 100;
  localparam int DRAIN_CYCLES   = 16;
  localparam int MAX_REPORTS    = 10;
  // The bank clearing pass after reset is the longest quiet stretch.
  localparam int WATCHDOG_LIMIT = 262144;

  typedef struct {
    logic [cmbp_pkg::OP_W-1:0]       op;
    logic [cmbp_pkg::TREE_W-1:0]     node;
    logic                            bit_val;
    logic [cmbp_pkg::BYTE_W-1:0]     byte_val;
    int                              reps;
    bit                              typed;
    logic [cmbp_pkg::PROB_OUT_W-1:0] prob;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 17;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{cmbp_pkg::OP_PREDICT, 8'd0,   1'b0, 8'h00, 1,  1'b1, 12'd2048},
    '{cmbp_pkg::OP_PREDICT, 8'd255, 1'b1, 8'hFF, 1,  1'b1, 12'd2048},
    '{cmbp_pkg::OP_UPDATE,  8'd255, 1'b1, 8'hFF, 12, 1'b0, 12'd0},
    '{cmbp_pkg::OP_PREDICT, 8'd255, 1'b0, 8'h00, 1,  1'b1, 12'd1},
    '{cmbp_pkg::OP_UPDATE,  8'd0,   1'b0, 8'h00, 12, 1'b0, 12'd0},
    '{cmbp_pkg::OP_PREDICT, 8'd0,   1'b0, 8'h00, 1,  1'b1, 12'd4095},
    '{OP_UNUSED,            8'd0,   1'b1, 8'hFF, 1,  1'b0, 12'd0},
    '{cmbp_pkg::OP_PREDICT, 8'd0,   1'b1, 8'hFF, 1,  1'b1, 12'd4095},
    '{cmbp_pkg::OP_PUSH,    8'd255, 1'b1, 8'hFF, 1,  1'b0, 12'd0},
    '{cmbp_pkg::OP_PREDICT, 8'd0,   1'b0, 8'h00, 1,  1'b0, 12'd0},
    '{cmbp_pkg::OP_PUSH,    8'd0,   1'b0, 8'h80, 1,  1'b0, 12'd0},
    '{cmbp_pkg::OP_PUSH,    8'd0,   1'b0, 8'h01, 1,  1'b0, 12'd0},
    '{cmbp_pkg::OP_PUSH,    8'd0,   1'b0, 8'h7F, 1,  1'b0, 12'd0},
    '{cmbp_pkg::OP_PREDICT, 8'd255, 1'b0, 8'h00, 1,  1'b0, 12'd0},
    '{cmbp_pkg::OP_PUSH,    8'd0,   1'b0, 8'h00, 1,  1'b0, 12'd0},
    '{cmbp_pkg::OP_UPDATE,  8'd128, 1'b1, 8'h00, 1,  1'b0, 12'd0},
    '{cmbp_pkg::OP_PREDICT, 8'd128, 1'b0, 8'h00, 1,  1'b0, 12'd0}
  };

  logic [cmbp_pkg::BYTE_W-1:0] common_bytes [4] = '{8'h00, 8'hFF, 8'h20, 8'h65};

  logic clk;
  logic rst_n;

  cmbp_in_if  in_chan();
  cmbp_out_if out_chan();

  context_mixed_bit_probability_model_unit #(
    .UNITS(UNITS),
    .TREE_NODES(TREE_NODES),
    .SYMBOLS(SYMBOLS),
    .PROB_BITS(PROB_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  // Entries never written stay at half scale, so the bank is kept sparse.
  logic [PROB_BITS-1:0]            prob_bank [int unsigned];
  logic [cmbp_pkg::BYTE_W-1:0]     history [UNITS];
  logic [cmbp_pkg::PROB_OUT_W-1:0] expected_probs [$];

  int  items_sent;
  int  results_checked;
  int  mismatch_count;
  bit  tail_phase;
  bit  sender_gaps;
  bit  receiver_stalls;
  bit  long_hold_done;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned entry_key(int unsigned u,
                                            logic [cmbp_pkg::TREE_W-1:0] node);
    return (u * SYMBOLS + history[u] % SYMBOLS) * TREE_NODES + node % TREE_NODES;
  endfunction

  function automatic int unsigned entry_value(int unsigned key);
    return prob_bank.exists(key) ? prob_bank[key] : HALF_SCALE;
  endfunction

  function automatic logic [cmbp_pkg::PROB_OUT_W-1:0] mixed_probability(
      logic [cmbp_pkg::TREE_W-1:0] node);
    int unsigned acc;
    int unsigned wsum;
    int unsigned w;
    acc  = 0;
    wsum = 0;
    for (int u = 0; u < UNITS; u++) begin
      w    = (UNITS - u) * (UNITS - u);
      wsum += w;
      acc  += entry_value(entry_key(u, node)) * w;
    end
    return cmbp_pkg::PROB_OUT_W'((acc / wsum) & 32'hFFF);
  endfunction

  function automatic void move_entries(logic [cmbp_pkg::TREE_W-1:0] node, logic one);
    int unsigned key;
    int unsigned p;
    for (int u = 0; u < UNITS; u++) begin
      key = entry_key(u, node);
      p   = entry_value(key);
      if (one) begin
        p = p - (p >> cmbp_pkg::MOVE_SHIFT);
      end else begin
        p = p + ((FULL_SCALE - p) >> cmbp_pkg::MOVE_SHIFT);
      end
      prob_bank[key] = p[PROB_BITS-1:0];
    end
  endfunction

  function automatic void shift_history(logic [cmbp_pkg::BYTE_W-1:0] value);
    for (int u = UNITS - 1; u > 0; u--) begin
      history[u] = history[u-1];
    end
    history[0] = value;
  endfunction

  function automatic void note_mismatch(string what, logic [cmbp_pkg::PROB_OUT_W-1:0] want,
                                        logic [cmbp_pkg::PROB_OUT_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // Offers one request and waits for its acceptance; the model state follows
  // the edge at which the request was taken.
  task automatic send_request(input logic [cmbp_pkg::OP_W-1:0] op,
                              input logic [cmbp_pkg::TREE_W-1:0] node,
                              input logic bit_val, input logic [cmbp_pkg::BYTE_W-1:0] byte_val,
                              input bit typed,
                              input logic [cmbp_pkg::PROB_OUT_W-1:0] typed_prob);
    if (!tail_phase && sender_gaps && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.operation  <= op;
    in_chan.tree_node  <= node;
    in_chan.bit_req    <= bit_val;
    in_chan.byte_value <= byte_val;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    case (op)
      cmbp_pkg::OP_PREDICT: begin
        expected_probs.push_back(typed ? typed_prob : mixed_probability(node));
      end
      cmbp_pkg::OP_UPDATE:  move_entries(node, bit_val);
      cmbp_pkg::OP_PUSH:    shift_history(byte_val);
      default:              ;
    endcase
    if (op != OP_UNUSED) begin
      items_sent++;
    end
    tail_phase = items_sent >= DIRECTED_ROWS + ITEM_TARGET - TAIL_ITEMS;
    if ($urandom_range(0, 40) == 0) begin
      sender_gaps = !sender_gaps;
    end
  endtask

  // Walks the bit tree of one byte the way a coder does: predict, then update,
  // for each bit from the top, then push the finished byte. A stop point below
  // eight abandons the byte after that many bits.
  task automatic code_byte(input logic [cmbp_pkg::BYTE_W-1:0] value, input int stop_at);
    logic [cmbp_pkg::TREE_W-1:0] node;
    node = 8'd1;
    for (int i = 7; i >= 0; i--) begin
      if (7 - i == stop_at) return;
      send_request(cmbp_pkg::OP_PREDICT, node, 1'($urandom),
                   cmbp_pkg::BYTE_W'($urandom), 1'b0, '0);
      send_request(cmbp_pkg::OP_UPDATE, node, value[i],
                   cmbp_pkg::BYTE_W'($urandom), 1'b0, '0);
      node = {node[cmbp_pkg::TREE_W-2:0], value[i]};
    end
    send_request(cmbp_pkg::OP_PUSH, cmbp_pkg::TREE_W'($urandom), 1'($urandom), value,
                 1'b0, '0);
  endtask

  initial begin
    logic [cmbp_pkg::BYTE_W-1:0] value;
    int                          pick;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.operation  <= cmbp_pkg::OP_PREDICT;
    in_chan.tree_node  <= '0;
    in_chan.bit_req    <= 1'b0;
    in_chan.byte_value <= '0;
    for (int u = 0; u < UNITS; u++) begin
      history[u] = '0;
    end
    items_sent      = 0;
    results_checked = 0;
    mismatch_count  = 0;
    tail_phase      = 1'b0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    long_hold_done  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      repeat (directed_rows[r].reps) begin
        send_request(directed_rows[r].op, directed_rows[r].node, directed_rows[r].bit_val,
                     directed_rows[r].byte_val, directed_rows[r].typed, directed_rows[r].prob);
      end
    end

    while (items_sent < DIRECTED_ROWS + ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 9) < 6) begin
        value = common_bytes[$urandom_range(0, 3)];
      end else begin
        value = cmbp_pkg::BYTE_W'($urandom);
      end
      if (pick <= 6) begin
        code_byte(value, 8);
      end else if (pick == 7) begin
        code_byte(value, $urandom_range(0, 7));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_request(cmbp_pkg::OP_W'($urandom_range(0, 3)), cmbp_pkg::TREE_W'($urandom),
                       1'($urandom), cmbp_pkg::BYTE_W'($urandom), 1'b0, '0);
        end
      end
    end
    in_chan.valid <= 1'b0;

    while (expected_probs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off that backs the
  // block up until it refuses new requests.
  initial begin
    out_chan.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!long_hold_done && results_checked >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!tail_phase && receiver_stalls && $urandom_range(0, 4) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      if ($urandom_range(0, 31) == 0) begin
        receiver_stalls = !receiver_stalls;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_probs.size() == 0) begin
        note_mismatch("probability with no request outstanding", 'x, out_chan.probability);
      end else begin
        if (out_chan.probability !== expected_probs[0]) begin
          note_mismatch("probability", expected_probs[0], out_chan.probability);
        end
        void'(expected_probs.pop_front());
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    int idle_cycles;
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
